// ----- hw/rtl/tisb_pkg.sv -----
// Package: widths, reset values, register indexes and the configuration struct.
`default_nettype none
package tisb_pkg;

  localparam int unsigned IDLE_W    = 22;
  localparam int unsigned PERIOD_W  = 11;
  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned TIMEOUT_W = 12;
  localparam int unsigned LONG_W    = 14;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [IDLE_W-1:0]     MS_PER_SECOND     = IDLE_W'(1000);
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = TIMEOUT_W'(300);
  localparam logic [LONG_W-1:0]     LONG_PRESS_RESET  = LONG_W'(3000);
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = DEBOUNCE_W'(50);
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET      = PERIOD_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT_SECONDS   = 2'd0,
    REG_LONG_PRESS_MS     = 2'd1,
    REG_DEBOUNCE_MS       = 2'd2,
    REG_REFRESH_PERIOD_MS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [IDLE_W-1:0]     timeout_ms;
    logic [LONG_W-1:0]     long_press_ms;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [PERIOD_W-1:0]   refresh_period_ms;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tisb_if.sv -----
// Interfaces: tick input channel, result output channel, configuration write channel.
`default_nettype none
interface tisb_tick_if;
  logic valid;
  logic ready;
  logic touch_pressed;
  modport source (output valid, output touch_pressed, input ready);
  modport sink (input valid, input touch_pressed, output ready);
endinterface

interface tisb_result_if;
  logic valid;
  logic ready;
  logic blanked;
  logic entered_blank;
  logic woke_up;
  logic refresh_pulse;
  modport source (output valid, output blanked, output entered_blank,
                  output woke_up, output refresh_pulse, input ready);
  modport sink (input valid, input blanked, input entered_blank,
                input woke_up, input refresh_pulse, output ready);
endinterface

interface tisb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tisb_pkg::CFG_IDX_W-1:0]  index;
  logic [tisb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tisb_cfg.sv -----
// Configuration register file; holds the timeout already scaled to milliseconds.
`default_nettype none
module tisb_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  tisb_cfg_if.sink      cfg,
  output tisb_pkg::cfg_t regs
);
  import tisb_pkg::*;

  cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.timeout_ms        <= IDLE_W'(TIMEOUT_RESET) * MS_PER_SECOND;
      regs_q.long_press_ms     <= LONG_PRESS_RESET;
      regs_q.debounce_ms       <= DEBOUNCE_RESET;
      regs_q.refresh_period_ms <= PERIOD_RESET;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        REG_TIMEOUT_SECONDS: begin
          regs_q.timeout_ms <= IDLE_W'(cfg.data[TIMEOUT_W-1:0]) * MS_PER_SECOND;
        end
        REG_LONG_PRESS_MS: begin
          regs_q.long_press_ms <= cfg.data[LONG_W-1:0];
        end
        REG_DEBOUNCE_MS: begin
          regs_q.debounce_ms <= cfg.data[DEBOUNCE_W-1:0];
        end
        REG_REFRESH_PERIOD_MS: begin
          regs_q.refresh_period_ms <= cfg.data[PERIOD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/touch_idle_screen_blanker_core.sv -----
// Top level: screen blanker state update per millisecond tick and result register.
`default_nettype none
// One beat on tick_in is one millisecond tick carrying the raw touch level; each
// tick yields exactly one result beat on result_out, in the cycle after it is taken.
// The block takes a tick in every cycle while the result register is empty or its
// beat is being taken in the same cycle; while result_out is ready the sustained
// rate is one tick per cycle, set by the combinational state update.
// Configuration writes are always taken and act on ticks taken after them; the
// timeout is converted to milliseconds when its register is written.
module touch_idle_screen_blanker_core (
  input  wire logic   clk,
  input  wire logic   rst,
  tisb_tick_if.sink   tick_in,
  tisb_result_if.source result_out,
  tisb_cfg_if.sink    cfg
);
  import tisb_pkg::*;

  cfg_t regs;

  tisb_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  logic                  saver_on, saver_on_next;
  logic [IDLE_W-1:0]     idle_count, idle_count_next;
  logic [PERIOD_W-1:0]   refresh_count, refresh_count_next;
  logic                  press_seen, press_seen_next;
  logic [COUNT_W-1:0]    press_count, press_count_next;
  logic                  hold_tracking, hold_tracking_next;
  logic [COUNT_W-1:0]    hold_count, hold_count_next;
  logic                  activity_counted, activity_counted_next;
  logic                  wait_release, wait_release_next;
  logic                  entered_next, woke_next, refresh_next;
  logic                  real_touch;
  logic                  accept;

  logic out_valid, out_blanked, out_entered, out_woke, out_refresh;

  assign tick_in.ready = !out_valid || result_out.ready;
  assign accept        = tick_in.valid && tick_in.ready;

  assign result_out.valid         = out_valid;
  assign result_out.blanked       = out_blanked;
  assign result_out.entered_blank = out_entered;
  assign result_out.woke_up       = out_woke;
  assign result_out.refresh_pulse = out_refresh;

  always_comb begin
    saver_on_next         = saver_on;
    refresh_count_next    = refresh_count;
    press_seen_next       = press_seen;
    press_count_next      = press_count;
    hold_tracking_next    = hold_tracking;
    hold_count_next       = hold_count;
    activity_counted_next = activity_counted;
    wait_release_next     = wait_release;
    entered_next          = 1'b0;
    woke_next             = 1'b0;
    refresh_next          = 1'b0;
    real_touch            = 1'b0;

    // refresh
    if (saver_on) begin
      if (refresh_count != '1) begin
        refresh_count_next = refresh_count + PERIOD_W'(1);
      end
      if (refresh_count_next >= regs.refresh_period_ms) begin
        refresh_next       = 1'b1;
        refresh_count_next = '0;
      end
    end

    // timeout
    idle_count_next = (idle_count == '1) ? idle_count : idle_count + IDLE_W'(1);
    if (!saver_on && regs.timeout_ms != '0 && idle_count_next > regs.timeout_ms) begin
      saver_on_next      = 1'b1;
      entered_next       = 1'b1;
      idle_count_next    = '0;
      refresh_count_next = '0;
    end

    // touch
    if (tick_in.touch_pressed) begin
      if (!press_seen) begin
        press_seen_next  = 1'b1;
        press_count_next = '0;
      end else if (press_count != '1) begin
        press_count_next = press_count + COUNT_W'(1);
      end
      real_touch = press_count_next >= COUNT_W'(regs.debounce_ms);

      if (saver_on_next && !wait_release && real_touch) begin
        saver_on_next         = 1'b0;
        woke_next             = 1'b1;
        idle_count_next       = '0;
        hold_tracking_next    = 1'b0;
        activity_counted_next = 1'b1;
      end else if (!saver_on_next && real_touch) begin
        if (!activity_counted) begin
          idle_count_next       = '0;
          activity_counted_next = 1'b1;
        end
        if (!hold_tracking) begin
          hold_tracking_next = 1'b1;
          hold_count_next    = '0;
        end else begin
          if (hold_count != '1) begin
            hold_count_next = hold_count + COUNT_W'(1);
          end
          if (hold_count_next >= regs.long_press_ms) begin
            saver_on_next      = 1'b1;
            entered_next       = 1'b1;
            idle_count_next    = '0;
            refresh_count_next = '0;
            hold_tracking_next = 1'b0;
            wait_release_next  = 1'b1;
          end
        end
      end
    end else begin
      hold_tracking_next    = 1'b0;
      hold_count_next       = '0;
      wait_release_next     = 1'b0;
      press_seen_next       = 1'b0;
      press_count_next      = '0;
      activity_counted_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saver_on         <= 1'b0;
      idle_count       <= '0;
      refresh_count    <= '0;
      press_seen       <= 1'b0;
      press_count      <= '0;
      hold_tracking    <= 1'b0;
      hold_count       <= '0;
      activity_counted <= 1'b0;
      wait_release     <= 1'b0;
    end else if (accept) begin
      saver_on         <= saver_on_next;
      idle_count       <= idle_count_next;
      refresh_count    <= refresh_count_next;
      press_seen       <= press_seen_next;
      press_count      <= press_count_next;
      hold_tracking    <= hold_tracking_next;
      hold_count       <= hold_count_next;
      activity_counted <= activity_counted_next;
      wait_release     <= wait_release_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_blanked <= saver_on_next;
      out_entered <= entered_next;
      out_woke    <= woke_next;
      out_refresh <= refresh_next;
    end
  end

endmodule
`default_nettype wire
